FILE: src/bmhq_pkg.sv
package bmhq_pkg;

  localparam int BMHQ_CAPACITY   = 64;
  localparam int BMHQ_VALUE_BITS = 32;
  localparam int DATA_W          = 32;

  localparam logic       OP_INSERT  = 1'b0;
  localparam logic       OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

FILE: src/bmhq_mem.sv
module bmhq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] ra_data,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: src/binary_max_heap_queue.sv
// Channel  Dir  Ports                 Beat contents (low bit up)
// in       in   in_tvalid/tready      tdata: value; tuser: func
// out      out  out_tvalid/tready     tdata: taken_value, top_value, count, is_empty;
//                                     tuser: status
//
// An insert writes straight into an empty heap; otherwise the value climbs level by
// level (S_UP, S_PLACE). An extract reads the last entry (S_LAST) and, unless the heap
// is then empty, sinks it level by level from the root (S_DOWN). A refused beat goes
// straight to S_FIN. The heap memory has two registered read ports.
// Reset clears the count and control; heap contents need no clearing.
// A waiting result holds the block in its final state until it is taken.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY   = BMHQ_CAPACITY,
  parameter int VALUE_BITS = BMHQ_VALUE_BITS,
  parameter int CW         = $clog2(CAPACITY + 1),
  parameter int OUT_W      = ((2 * DATA_W + CW + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // value
  input  logic              in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // taken_value, top_value, count, is_empty
  output logic [1:0]        out_tuser   // status
);

  localparam int VB = VALUE_BITS;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [VB-1:0] SIGN_C  = {1'b1, {(VB-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_DOWN  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [VB-1:0]     key_r, key_nxt;
  logic [VB-1:0]     top_r, top_nxt;
  logic [DATA_W-1:0] taken_r, taken_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  logic              we;
  logic [AW-1:0]     waddr, ra_addr, rb_addr;
  logic [VB-1:0]     wdata, ra_data, rb_data;

  logic [VB+DATA_W-1:0] in_wide, top_wide;
  logic [VB-1:0]        in_key;
  logic [DATA_W-1:0]    top_val;

  logic [CW-1:0] pos_m1, cnt_m1, par, gpar, gpar_m1;
  logic [CW:0]   lchild, rchild, best, bl, bl_m1;
  logic          lv, rv, lbig, rbig;
  logic [VB-1:0] bkey;

  assign in_wide  = {{VB{1'b0}}, in_tdata};
  assign in_key   = in_wide[VB-1:0] ^ SIGN_C;
  assign top_wide = {{DATA_W{1'b0}}, top_r ^ SIGN_C};
  assign top_val  = top_wide[DATA_W-1:0];

  assign pos_m1  = pos_r - ONE_C;
  assign cnt_m1  = cnt_r - ONE_C;
  assign par     = pos_r >> 1;
  assign gpar    = par >> 1;
  assign gpar_m1 = gpar - ONE_C;

  // children of the hole while sinking
  assign lchild = {pos_r, 1'b0};
  assign rchild = {pos_r, 1'b1};
  assign lv     = lchild <= {1'b0, cnt_r};
  assign rv     = rchild <= {1'b0, cnt_r};
  assign lbig   = lv && (key_r < ra_data);
  assign rbig   = rv && ((lbig ? ra_data : key_r) < rb_data);
  assign best   = rbig ? rchild : (lbig ? lchild : {1'b0, pos_r});
  assign bkey   = rbig ? rb_data : ra_data;
  assign bl     = {best[CW-1:0], 1'b0};
  assign bl_m1  = bl - (CW+1)'(1);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    top_nxt       = top_r;
    taken_nxt     = taken_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    we            = 1'b0;
    waddr         = pos_m1[AW-1:0];
    wdata         = key_r;
    ra_addr       = '0;
    rb_addr       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          taken_nxt  = '0;
          status_nxt = ST_OK;
          if (in_tuser == OP_INSERT) begin
            if (cnt_r == CAP_C) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              cnt_nxt = cnt_r + ONE_C;
              pos_nxt = cnt_r + ONE_C;
              key_nxt = in_key;
              if (cnt_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = in_key;
                top_nxt   = in_key;
                state_nxt = S_FIN;
              end else begin
                ra_addr   = AW'((cnt_r + ONE_C) >> 1) - AW'(1);
                state_nxt = S_UP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              taken_nxt = top_val;
              ra_addr   = cnt_m1[AW-1:0];
              cnt_nxt   = cnt_m1;
              state_nxt = S_LAST;
            end
          end
        end
      end
      S_LAST: begin
        key_nxt = ra_data;
        pos_nxt = ONE_C;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          ra_addr   = AW'(1);
          rb_addr   = AW'(2);
          state_nxt = S_DOWN;
        end
      end
      S_UP: begin
        we = 1'b1;
        if (ra_data < key_r) begin
          wdata   = ra_data;
          pos_nxt = par;
          if (par == ONE_C) begin
            state_nxt = S_PLACE;
          end else begin
            ra_addr = gpar_m1[AW-1:0];
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        state_nxt = S_FIN;
        if (pos_r == ONE_C) begin
          top_nxt = key_r;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (lbig || rbig) begin
          wdata   = bkey;
          pos_nxt = best[CW-1:0];
          ra_addr = bl_m1[AW-1:0];
          rb_addr = bl[AW-1:0];
          if (pos_r == ONE_C) begin
            top_nxt = bkey;
          end
        end else begin
          state_nxt = S_FIN;
          if (pos_r == ONE_C) begin
            top_nxt = key_r;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt                   = '0;
          out_data_nxt[DATA_W-1:0]       = taken_r;
          out_data_nxt[2*DATA_W-1:DATA_W] = (cnt_r == '0) ? '0 : top_val;
          out_data_nxt[2*DATA_W+CW-1:2*DATA_W] = cnt_r;
          out_data_nxt[2*DATA_W+CW]      = (cnt_r == '0);
          out_user_nxt                   = status_r;
          state_nxt                      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    top_r      <= top_nxt;
    taken_r    <= taken_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  bmhq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VB),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
